### hdl/ctc_pkg.sv
// Shared types and constants for the text console cursor and scroll engine.
package ctc_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int CELL_W      = 16;
  localparam int CODE_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int COL_OUT_W   = 7;
  localparam int ROW_OUT_W   = 5;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CODE_W-1:0] ATTR_RESET   = 8'h05;

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RDWAIT,
    ST_COPY,
    ST_BLANK,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic                 scrolled;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [CELL_W-1:0]    cell_data;
  } res_t;

endpackage

### hdl/ctc_cell_ram.sv
// Character cell store: one write port, one read port, registered read data.
module ctc_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ctc_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ctc_pkg::CELL_W-1:0] rdata
);
  import ctc_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/ctc_seq.sv
// Sequencer: cursor update, scroll copy, row blanking, clear and reads on the cell store.
module ctc_seq #(
  parameter int COLUMNS = ctc_pkg::COLUMNS_DEF,
  parameter int ROWS    = ctc_pkg::ROWS_DEF,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int AW      = $clog2(CELLS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [ctc_pkg::CODE_W-1:0]  char_code,
  input  logic [ctc_pkg::INDEX_W-1:0] cell_index,
  input  logic                        cfg_wen,
  input  logic [ctc_pkg::CODE_W-1:0]  cfg_wdata,
  output logic                        we,
  output logic [AW-1:0]               waddr,
  output logic [ctc_pkg::CELL_W-1:0]  wdata,
  output logic                        re,
  output logic [AW-1:0]               raddr,
  input  logic [ctc_pkg::CELL_W-1:0]  rdata,
  output logic                        res_valid,
  output ctc_pkg::res_t               res,
  input  logic                        res_take
);
  import ctc_pkg::*;

  localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COPY_LAST = (ROWS - 1) * COLUMNS;

  state_t            state, state_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     cur_col, cur_col_next;
  logic [LW-1:0]     cur_line, cur_line_next;
  logic [AW-1:0]     blank_base, blank_base_next;
  logic              scroll_flag, scroll_flag_next;
  logic              rd_ok, rd_ok_next;
  logic [CODE_W-1:0] attr;
  logic              accept;
  logic              finish;

  logic              is_nl;
  logic              wrap;
  logic              line_step;
  logic              scroll_hit;
  logic [CW:0]       col_inc;
  logic [LW:0]       line_inc;
  logic [CW-1:0]     col_put;
  logic [LW-1:0]     line_put;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     row_addr;
  logic [CELL_W-1:0] blank_cell;

  assign in_ready   = (state == ST_IDLE) && !res_valid;
  assign accept     = in_valid && in_ready;
  assign blank_cell = {attr, BLANK_CODE};

  // cursor arithmetic for a put
  always_comb begin
    is_nl      = (char_code == NEWLINE_CODE);
    col_inc    = {1'b0, cur_col} + (CW+1)'(1);
    line_inc   = {1'b0, cur_line} + (LW+1)'(1);
    wrap       = !is_nl && (col_inc == (CW+1)'(COLUMNS));
    line_step  = is_nl || wrap;
    scroll_hit = line_step && (line_inc == (LW+1)'(ROWS));
    col_put    = line_step ? '0 : col_inc[CW-1:0];
    if (scroll_hit) begin
      line_put = LW'(ROWS - 1);
    end else if (line_step) begin
      line_put = line_inc[LW-1:0];
    end else begin
      line_put = cur_line;
    end
    cur_addr = AW'(cur_line * COLUMNS) + AW'(cur_col);
    row_addr = AW'(line_put * COLUMNS);
  end

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    cur_col_next     = cur_col;
    cur_line_next    = cur_line;
    blank_base_next  = blank_base;
    scroll_flag_next = scroll_flag;
    rd_ok_next       = rd_ok;
    finish           = 1'b0;
    we               = 1'b0;
    waddr            = ptr;
    wdata            = blank_cell;
    re               = 1'b0;
    raddr            = ptr + AW'(COLUMNS);
    case (state)
      ST_INIT: begin
        we    = 1'b1;
        wdata = '0;
        if (ptr == AW'(CELLS - 1)) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scroll_flag_next = 1'b0;
          case (mode_t'(mode))
            MODE_PUT: begin
              we               = !is_nl;
              waddr            = cur_addr;
              wdata            = {attr, char_code};
              cur_col_next     = col_put;
              cur_line_next    = line_put;
              scroll_flag_next = scroll_hit;
              blank_base_next  = row_addr;
              if (scroll_hit) begin
                ptr_next   = '0;
                state_next = ST_COPY;
              end else if (col_put == '0) begin
                ptr_next   = row_addr;
                state_next = ST_BLANK;
              end else begin
                finish = 1'b1;
              end
            end
            MODE_READ: begin
              re         = 1'b1;
              raddr      = AW'(cell_index);
              rd_ok_next = (32'(cell_index) < CELLS);
              state_next = ST_RDWAIT;
            end
            MODE_CLEAR: begin
              ptr_next   = '0;
              state_next = ST_FILL;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        finish     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        // read one row ahead, write back the word fetched last cycle
        re    = (ptr != AW'(COPY_LAST));
        we    = (ptr != '0);
        waddr = ptr - AW'(1);
        wdata = rdata;
        if (ptr == AW'(COPY_LAST)) begin
          ptr_next   = blank_base;
          state_next = ST_BLANK;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      ST_BLANK: begin
        we = 1'b1;
        if (ptr == blank_base + AW'(COLUMNS - 1)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (ptr == AW'(CELLS - 1)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      ptr         <= '0;
      cur_col     <= '0;
      cur_line    <= '0;
      scroll_flag <= 1'b0;
      attr        <= ATTR_RESET;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      ptr         <= ptr_next;
      cur_col     <= cur_col_next;
      cur_line    <= cur_line_next;
      scroll_flag <= scroll_flag_next;
      if (cfg_wen) begin
        attr <= cfg_wdata;
      end
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blank_base <= blank_base_next;
    rd_ok      <= rd_ok_next;
    if (finish) begin
      res.cursor_col <= COL_OUT_W'(cur_col_next);
      res.cursor_row <= ROW_OUT_W'(cur_line_next);
      res.scrolled   <= scroll_flag_next;
      res.cell_data  <= (state == ST_RDWAIT && rd_ok) ? rdata : '0;
    end
  end

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLUMNS) && (32'(cur_line) < ROWS))
    else $error("cursor left the grid");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (32'(waddr) < CELLS))
    else $error("cell write beyond the store");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (res_valid || state != ST_IDLE))
    else $error("accepted word produced neither work nor result");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && re && we) |-> (raddr > waddr))
    else $error("scroll copy overtook its own writes");

  a_scroll_blanks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && state_next == ST_BLANK) |->
      (32'(cur_line) == ROWS - 1 && cur_col == '0))
    else $error("scroll did not land on the bottom row");

endmodule

### hdl/text_console_cursor_scroll.sv
// Text console engine: cell store, cursor sequencer and result output stage.
//
// Input words on s_axis carry one command each: tuser selects put character,
// read cell or clear screen. Every accepted word gives exactly one result word
// on m_axis with the read cell (zero unless reading), the cursor after the
// command and a scroll flag. cfg_wen/cfg_wdata set the attribute byte placed
// above each written code and each blank.
// With m_axis ready, the result reaches m_axis in the same cycle as the next
// word can be taken. Work per command:
//   put without wrap: the cell write only; read: a wait state for the read data;
//   put that lands on column 0: row blank, one cell a cycle;
//   put that scrolls: row copy, then blank;
//   clear: every cell filled with a blank.
// The one-port-each-way cell memory sets this pace: every cell moved or
// blanked costs one write.
// After reset the store is zeroed in a pass over all cells with
// s_axis_tready low; cursor goes to 0,0 and the attribute to 5.
// A stalled m_axis holds its word while one more command is taken and run;
// its result waits in the sequencer until the output frees.
module text_console_cursor_scroll #(
  parameter int COLUMNS = ctc_pkg::COLUMNS_DEF,
  parameter int ROWS    = ctc_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero fill
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cell_data[15:0], cursor_col[22:16],
                                      // cursor_row[27:23], scrolled[28], zero fill
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata
);
  import ctc_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;
  logic              res_valid;
  res_t              res;
  logic              res_take;
  res_t              out_word;

  ctc_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ctc_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .AW      (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .mode       (s_axis_tuser),
    .char_code  (s_axis_tdata[7:0]),
    .cell_index (s_axis_tdata[18:8]),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // advance the waiting result into the output register when it frees
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_word.scrolled, out_word.cursor_row,
                         out_word.cursor_col, out_word.cell_data};

endmodule
